// ===== design/radio_packet_rx_deframer_macros.svh =====
// ---------------------------------------------------------------------------
// radio packet rx deframer assertion macros
// clocked concurrent assertion helpers for the deframer control rtl
// ---------------------------------------------------------------------------
`ifndef RADIO_PACKET_RX_DEFRAMER_MACROS_SVH
`define RADIO_PACKET_RX_DEFRAMER_MACROS_SVH

// property holds on every edge out of reset
`define RPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define RPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/rpd_pkg.sv =====
// ---------------------------------------------------------------------------
// rpd_pkg
// request and result types, op and event codes, crc byte update
// ---------------------------------------------------------------------------
package rpd_pkg;

    localparam logic [1:0] OP_RX      = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_POLL    = 2'd2;
    localparam logic [1:0] OP_RELEASE = 2'd3;

    localparam logic [1:0] EV_STORED  = 2'd0;
    localparam logic [1:0] EV_DROP    = 2'd1;
    localparam logic [1:0] EV_DONE    = 2'd2;
    localparam logic [1:0] EV_NONE    = 2'd3;

    localparam logic [7:0]  HDR_XOR_OK = 8'hFF;
    localparam logic [15:0] CRC_INIT   = 16'h0000;
    localparam logic [15:0] CRC_POLY   = 16'h8408;
    localparam logic [7:0]  MIN_LEN    = 8'd2;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] rx_byte;
        logic [6:0] read_index;
    } in_item_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic [7:0] read_byte;
        logic       frame_ready;
        logic [5:0] payload_len;
    } out_item_t;

    typedef struct packed {
        logic [1:0] event_res;
        logic       rd_en;
        logic       frame_ready;
        logic [5:0] payload_len;
    } rpd_meta_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== design/rpd_store.sv =====
// ---------------------------------------------------------------------------
// rpd_store
// frame byte memory for both packet buffers, one port, registered read
// ---------------------------------------------------------------------------
module rpd_store #(
    parameter int DEPTH  = 136,
    parameter int ADDR_W = 8
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wdata,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rpd_ctrl.sv =====
// ---------------------------------------------------------------------------
// rpd_ctrl
// frame receive state, header check, crc lag, buffer ownership, store access
// ---------------------------------------------------------------------------
`include "radio_packet_rx_deframer_macros.svh"

module rpd_ctrl
    import rpd_pkg::*;
#(
    parameter int HEADER_BYTES = 4,
    parameter int MAX_DATA     = 64,
    parameter int DEST_POS     = 0,
    parameter int SRC_POS      = 1,
    parameter int LEN_POS      = 2,
    parameter int SLOT_BYTES   = 68,
    parameter int ADDR_W       = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  in_item_t          item,
    input  logic [7:0]        own_addr,
    output logic              mem_we,
    output logic              mem_re,
    output logic [ADDR_W-1:0] mem_addr,
    output logic [7:0]        mem_wdata,
    output rpd_meta_t         meta
);

    localparam int POS_W = $clog2(SLOT_BYTES + 1);
    localparam int CMP_W = $clog2(HEADER_BYTES + 256) + 1;

    logic             receiving_reg, receiving_next;
    logic [POS_W-1:0] byte_pos_reg, byte_pos_next;
    logic [7:0]       header_xor_reg, header_xor_next;
    logic             write_sel_reg, write_sel_next;
    logic             read_sel_reg, read_sel_next;
    logic             buf_full_reg [2];
    logic             buf_full_next [2];
    logic             buf_crc_good_reg [2];
    logic             buf_crc_good_next [2];
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       lag0_reg, lag0_next;
    logic [7:0]       lag1_reg, lag1_next;
    logic [7:0]       dest_reg [2];
    logic [7:0]       dest_next [2];
    logic [7:0]       src_reg [2];
    logic [7:0]       src_next [2];
    logic [7:0]       len_reg [2];
    logic [7:0]       len_next [2];

    logic             rx_op;
    logic             wr_first;
    logic             wr_mid;
    logic             wr_en;
    logic [POS_W-1:0] wpos;
    logic [7:0]       dest_v;
    logic [7:0]       src_v;
    logic [7:0]       len_v;
    logic [1:0]       ev;
    logic             rd_ok;
    logic             ready;
    logic [7:0]       plen_full;
    logic [ADDR_W-1:0] mem_pos;
    logic             mem_sel;

    assign rx_op    = fire && (item.op == OP_RX);
    assign wr_first = rx_op && !receiving_reg && !buf_full_reg[write_sel_reg];
    assign wr_mid   = rx_op && receiving_reg &&
                      (CMP_W'(byte_pos_reg) < CMP_W'(SLOT_BYTES));
    assign wr_en    = wr_first || wr_mid;
    assign wpos     = wr_first ? '0 : byte_pos_reg;

    // header byte shadows, updated with the byte written this cycle
    always_comb
    begin
        dest_next = dest_reg;
        src_next  = src_reg;
        len_next  = len_reg;
        if (wr_en)
        begin
            if (CMP_W'(wpos) == CMP_W'(DEST_POS))
            begin
                dest_next[write_sel_reg] = item.rx_byte;
            end
            if (CMP_W'(wpos) == CMP_W'(SRC_POS))
            begin
                src_next[write_sel_reg] = item.rx_byte;
            end
            if (CMP_W'(wpos) == CMP_W'(LEN_POS))
            begin
                len_next[write_sel_reg] = item.rx_byte;
            end
        end
    end

    assign dest_v = (DEST_POS < SLOT_BYTES) ? dest_next[write_sel_reg] : 8'h00;
    assign src_v  = (SRC_POS < SLOT_BYTES) ? src_next[write_sel_reg] : 8'h00;
    assign len_v  = (LEN_POS < SLOT_BYTES) ? len_next[write_sel_reg] : 8'h00;

    always_comb
    begin
        receiving_next    = receiving_reg;
        byte_pos_next     = byte_pos_reg;
        header_xor_next   = header_xor_reg;
        write_sel_next    = write_sel_reg;
        read_sel_next     = read_sel_reg;
        buf_full_next     = buf_full_reg;
        buf_crc_good_next = buf_crc_good_reg;
        crc_next          = crc_reg;
        lag0_next         = lag0_reg;
        lag1_next         = lag1_reg;
        ev                = EV_NONE;
        rd_ok             = 1'b0;
        if (fire)
        begin
            unique case (item.op)
                OP_RX:
                begin
                    if (!receiving_reg)
                    begin
                        if (buf_full_reg[write_sel_reg])
                        begin
                            ev = EV_DROP;
                        end
                        else
                        begin
                            receiving_next  = 1'b1;
                            byte_pos_next   = POS_W'(1);
                            header_xor_next = item.rx_byte;
                            crc_next        = CRC_INIT;
                            lag0_next       = 8'h00;
                            lag1_next       = 8'h00;
                            buf_crc_good_next[write_sel_reg] = 1'b0;
                            ev              = EV_STORED;
                        end
                    end
                    else if (!wr_mid)
                    begin
                        receiving_next = 1'b0;
                        ev             = EV_DROP;
                    end
                    else
                    begin
                        if (CMP_W'(byte_pos_reg) >= CMP_W'(HEADER_BYTES))
                        begin
                            if (CMP_W'(byte_pos_reg) >= CMP_W'(HEADER_BYTES + 2))
                            begin
                                crc_next = crc16_byte(crc_reg, lag0_reg);
                            end
                            lag0_next = lag1_reg;
                            lag1_next = item.rx_byte;
                        end
                        byte_pos_next   = byte_pos_reg + POS_W'(1);
                        header_xor_next = header_xor_reg ^ item.rx_byte;
                        ev              = EV_STORED;
                        if ((CMP_W'(byte_pos_next) == CMP_W'(HEADER_BYTES)) &&
                            ((header_xor_next != HDR_XOR_OK) || (dest_v != own_addr) ||
                             (src_v == own_addr) || (len_v > 8'(MAX_DATA))))
                        begin
                            receiving_next = 1'b0;
                            ev             = EV_DROP;
                        end
                        else if ((CMP_W'(byte_pos_next) >= CMP_W'(HEADER_BYTES)) &&
                                 (CMP_W'(byte_pos_next) ==
                                  CMP_W'(HEADER_BYTES) + CMP_W'(len_v)))
                        begin
                            buf_crc_good_next[write_sel_reg] = (len_v >= MIN_LEN) &&
                                (crc_next == {lag1_next, lag0_next});
                            buf_full_next[write_sel_reg] = 1'b1;
                            write_sel_next = ~write_sel_reg;
                            receiving_next = 1'b0;
                            ev             = EV_DONE;
                        end
                    end
                end
                OP_READ:
                begin
                    rd_ok = CMP_W'(item.read_index) < CMP_W'(SLOT_BYTES);
                end
                OP_POLL:
                begin
                    if (buf_full_reg[read_sel_reg] && !buf_crc_good_reg[read_sel_reg])
                    begin
                        buf_full_next[read_sel_reg] = 1'b0;
                        read_sel_next = ~read_sel_reg;
                    end
                end
                OP_RELEASE:
                begin
                    if (buf_full_reg[read_sel_reg])
                    begin
                        buf_full_next[read_sel_reg] = 1'b0;
                        read_sel_next = ~read_sel_reg;
                    end
                end
                default:
                begin
                    ev = EV_NONE;
                end
            endcase
        end
    end

    assign ready     = buf_full_next[read_sel_next] && buf_crc_good_next[read_sel_next];
    assign plen_full = ((LEN_POS < SLOT_BYTES) ? len_next[read_sel_next] : 8'h00) - MIN_LEN;

    assign meta.event_res   = ev;
    assign meta.rd_en       = rd_ok;
    assign meta.frame_ready = ready;
    assign meta.payload_len = ready ? plen_full[5:0] : 6'd0;

    // store port: write of a received byte or read for a read request
    assign mem_we    = wr_en;
    assign mem_re    = rd_ok;
    assign mem_wdata = item.rx_byte;
    assign mem_sel   = wr_en ? write_sel_reg : read_sel_reg;
    assign mem_pos   = wr_en ? ADDR_W'(wpos) : ADDR_W'(item.read_index);
    assign mem_addr  = mem_sel ? (ADDR_W'(SLOT_BYTES) + mem_pos) : mem_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receiving_reg       <= 1'b0;
            byte_pos_reg        <= '0;
            header_xor_reg      <= 8'h00;
            write_sel_reg       <= 1'b0;
            read_sel_reg        <= 1'b0;
            buf_full_reg[0]     <= 1'b0;
            buf_full_reg[1]     <= 1'b0;
            buf_crc_good_reg[0] <= 1'b0;
            buf_crc_good_reg[1] <= 1'b0;
            crc_reg             <= CRC_INIT;
            lag0_reg            <= 8'h00;
            lag1_reg            <= 8'h00;
        end
        else
        begin
            receiving_reg    <= receiving_next;
            byte_pos_reg     <= byte_pos_next;
            header_xor_reg   <= header_xor_next;
            write_sel_reg    <= write_sel_next;
            read_sel_reg     <= read_sel_next;
            buf_full_reg     <= buf_full_next;
            buf_crc_good_reg <= buf_crc_good_next;
            crc_reg          <= crc_next;
            lag0_reg         <= lag0_next;
            lag1_reg         <= lag1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dest_reg <= dest_next;
        src_reg  <= src_next;
        len_reg  <= len_next;
    end

    `RPD_ASSERT(a_rx_buf_free, receiving_reg |-> !buf_full_reg[write_sel_reg], "receiving into a full buffer")
    `RPD_ASSERT(a_one_port, !(mem_we && mem_re), "store write and read in one cycle")
    `RPD_ASSERT(a_pos_range, CMP_W'(byte_pos_reg) <= CMP_W'(SLOT_BYTES), "byte position past buffer end")
    `RPD_ASSERT_NEXT(a_done_toggle, fire && (ev == EV_DONE), (write_sel_reg != $past(write_sel_reg)) && buf_full_reg[$past(write_sel_reg)], "completed frame did not switch buffers")

endmodule

// ===== design/radio_packet_rx_deframer.sv =====
// ---------------------------------------------------------------------------
// radio_packet_rx_deframer
// receive deframer with header check, crc16 and a double packet buffer
// ---------------------------------------------------------------------------
// in_valid/in_stall carry one request per accepted edge: a received byte,
// a read of a stored byte, a poll or a release. every request returns one
// result on out_valid/out_stall: receive event, read byte, frame ready flag
// and payload length of the read-side buffer after the request. the user must
// write the node address through cfg_valid/cfg_ready/cfg_data only while no
// request is in flight, unenforced by the block; cfg_ready is always high.
// the accepting edge registers the control update and the frame store access;
// the store's registered read data then lands in the output register, and
// out_valid rises with it. one request is taken every cycle while in_stall
// is low; the single store port carries either write or read.
// a stalled result holds in the output register while one more request is
// taken into the store read stage; in_stall rises only when both are full.
// reset clears the receive state, both buffers become free, the address
// reads zero and the frame store keeps whatever it held.
// ---------------------------------------------------------------------------
module radio_packet_rx_deframer
    import rpd_pkg::*;
#(
    parameter int HEADER_BYTES = 4,
    parameter int MAX_DATA     = 64,
    parameter int DEST_POS     = 0,
    parameter int SRC_POS      = 1,
    parameter int LEN_POS      = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  in_item_t   in_item,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    localparam int SLOT_BYTES = HEADER_BYTES + MAX_DATA;
    localparam int DEPTH      = 2 * SLOT_BYTES;
    localparam int ADDR_W     = $clog2(DEPTH);

    logic [7:0]        own_addr_reg;
    logic              s1_valid_reg, s1_valid_next;
    rpd_meta_t         s1_meta_reg;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg;
    logic              advance_out;
    logic              fire;
    rpd_meta_t         meta;
    logic              mem_we;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_addr;
    logic [7:0]        mem_wdata;
    logic [7:0]        mem_rdata;

    assign cfg_ready   = 1'b1;
    assign advance_out = !out_valid_reg || !out_stall;
    assign in_stall    = s1_valid_reg && !advance_out;
    assign fire        = in_valid && !in_stall;

    rpd_ctrl #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_DATA     (MAX_DATA),
        .DEST_POS     (DEST_POS),
        .SRC_POS      (SRC_POS),
        .LEN_POS      (LEN_POS),
        .SLOT_BYTES   (SLOT_BYTES),
        .ADDR_W       (ADDR_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (in_item),
        .own_addr  (own_addr_reg),
        .mem_we    (mem_we),
        .mem_re    (mem_re),
        .mem_addr  (mem_addr),
        .mem_wdata (mem_wdata),
        .meta      (meta)
    );

    rpd_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign s1_valid_next  = fire || (s1_valid_reg && !advance_out);
    assign out_valid_next = advance_out ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_addr_reg  <= 8'h00;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                own_addr_reg <= cfg_data;
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            s1_meta_reg <= meta;
        end
        if (advance_out && s1_valid_reg)
        begin
            out_item_reg.event_res   <= s1_meta_reg.event_res;
            out_item_reg.read_byte   <= s1_meta_reg.rd_en ? mem_rdata : 8'h00;
            out_item_reg.frame_ready <= s1_meta_reg.frame_ready;
            out_item_reg.payload_len <= s1_meta_reg.payload_len;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== tb/sv/deframer_checker.sv =====
// ---------------------------------------------------------------------------
// deframer_checker
// rx deframer scoreboard: own copy of receive state, both packet buffers and
// the node address, expected result per accepted request, field compare of
// each delivered result against the oldest expected one
// ---------------------------------------------------------------------------
module deframer_checker
    import rpd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_item_t  in_item,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_item_t out_item,
    input  logic      cfg_valid,
    input  logic      cfg_ready,
    input  logic [7:0] cfg_data,
    output int        mismatches,
    output int        results_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HDR_LEN  = 4;
    localparam int DATA_MAX = 64;
    localparam int DEST_AT  = 0;
    localparam int SRC_AT   = 1;
    localparam int LEN_AT   = 2;
    localparam int SLOT     = HDR_LEN + DATA_MAX;

    logic [7:0]  node_addr;
    bit          rcv;
    int          pos;
    logic [7:0]  hdr_xor;
    bit          wsel;
    bit          rsel;
    bit          full [2];
    bit          good [2];
    logic [15:0] crc;
    logic [7:0]  lag [2];
    logic [7:0]  store [2*SLOT] = '{default: 8'h00};
    out_item_t   due_results [$];
    out_item_t   want;
    int          fail_count;

    function automatic logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] v;
        v = c ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
            v = {1'b0, v[15:1]} ^ (v[0] ? CRC_POLY : 16'h0000);
        return v;
    endfunction

    function automatic logic [7:0] slot_rd(input bit sel, input int p);
        if (p >= SLOT)
            return 8'h00;
        return store[(sel ? SLOT : 0) + p];
    endfunction

    function automatic logic [1:0] take_byte(input logic [7:0] b);
        int flen;
        if (!rcv)
        begin
            if (full[wsel])
                return EV_DROP;
            store[wsel ? SLOT : 0] = b;
            rcv        = 1'b1;
            pos        = 1;
            hdr_xor    = b;
            crc        = CRC_INIT;
            lag[0]     = 8'h00;
            lag[1]     = 8'h00;
            good[wsel] = 1'b0;
            return EV_STORED;
        end
        if (pos >= SLOT)
        begin
            rcv = 1'b0;
            return EV_DROP;
        end
        store[(wsel ? SLOT : 0) + pos] = b;
        if (pos >= HDR_LEN)
        begin
            if (pos >= HDR_LEN + 2)
                crc = crc_step(crc, lag[0]);
            lag[0] = lag[1];
            lag[1] = b;
        end
        pos++;
        hdr_xor = hdr_xor ^ b;
        flen = slot_rd(wsel, LEN_AT);
        if (pos == HDR_LEN)
        begin
            if (hdr_xor != HDR_XOR_OK || slot_rd(wsel, DEST_AT) != node_addr ||
                slot_rd(wsel, SRC_AT) == node_addr || flen > DATA_MAX)
            begin
                rcv = 1'b0;
                return EV_DROP;
            end
        end
        if (pos >= HDR_LEN && pos == HDR_LEN + flen)
        begin
            good[wsel] = (flen >= 2) && (crc == {lag[1], lag[0]});
            full[wsel] = 1'b1;
            wsel       = ~wsel;
            rcv        = 1'b0;
            return EV_DONE;
        end
        return EV_STORED;
    endfunction

    function automatic out_item_t deframe_step(input in_item_t req);
        out_item_t  res;
        logic [7:0] flen;
        res = '0;
        res.event_res = EV_NONE;
        case (req.op)
            OP_RX:
                res.event_res = take_byte(req.rx_byte);
            OP_READ:
                res.read_byte = slot_rd(rsel, req.read_index);
            OP_POLL:
                if (full[rsel] && !good[rsel])
                begin
                    full[rsel] = 1'b0;
                    rsel = ~rsel;
                end
            default:
                if (full[rsel])
                begin
                    full[rsel] = 1'b0;
                    rsel = ~rsel;
                end
        endcase
        res.frame_ready = full[rsel] && good[rsel];
        if (res.frame_ready)
        begin
            flen = slot_rd(rsel, LEN_AT) - 8'd2;
            res.payload_len = flen[5:0];
        end
        return res;
    endfunction

    function automatic int field_bad(input string name, input logic [7:0] exp_v,
                                     input logic [7:0] got_v);
        if (exp_v === got_v)
            return 0;
        $display("%0t ns: %s expected %0d, got %0d", $time, name, exp_v, got_v);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_addr  = 8'h00;
            rcv        = 1'b0;
            pos        = 0;
            hdr_xor    = 8'h00;
            wsel       = 1'b0;
            rsel       = 1'b0;
            full       = '{1'b0, 1'b0};
            good       = '{1'b0, 1'b0};
            crc        = CRC_INIT;
            lag        = '{8'h00, 8'h00};
            fail_count = 0;
            due_results.delete();
            mismatches   <= 0;
            results_owed <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t ns: result with no request outstanding, expected none, got %p",
                             $time, out_item);
                    fail_count++;
                end
                else
                begin
                    want = due_results.pop_front();
                    fail_count += field_bad("event_res", want.event_res, out_item.event_res);
                    fail_count += field_bad("read_byte", want.read_byte, out_item.read_byte);
                    fail_count += field_bad("frame_ready", want.frame_ready,
                                            out_item.frame_ready);
                    fail_count += field_bad("payload_len", want.payload_len,
                                            out_item.payload_len);
                end
            end
            if (cfg_valid && cfg_ready)
                node_addr = cfg_data;
            if (in_valid && !in_stall)
                due_results.push_back(deframe_step(in_item));
            mismatches   <= fail_count;
            results_owed <= due_results.size();
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// rx deframer regression: both packet buffers filled first, then directed
// frames and reader requests, then random phases under several node
// addresses with good and broken frames, noise bytes, reads, polls and
// releases; both sides idle at random
// ---------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rpd_pkg::*;

    typedef enum int {
        FR_GOOD,
        FR_BAD_CRC,
        FR_CUT,
        FR_BAD_XOR,
        FR_WRONG_DEST,
        FR_OWN_SRC,
        FR_TOO_LONG
    } frame_kind_t;

    localparam int DATA_MAX = 64;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    in_item_t   in_item   = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_stall;
    logic       out_valid;
    out_item_t  out_item;
    logic       cfg_ready;
    int         mismatches;
    int         results_owed;

    logic [7:0] node_addr;
    logic [7:0] phase_addr [4];
    int         items_sent   = 0;
    int         results_seen = 0;
    int         hold_left    = 0;
    bit         no_gap       = 1'b0;
    bit         no_hold      = 1'b0;

    radio_packet_rx_deframer dut (.*);

    deframer_checker deframe_check (.*);

    always #6 clk = ~clk;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left = 0;
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (results_seen % 40 == 0)
                    no_hold = ($urandom_range(0, 3) == 0);
                hold_left = no_hold ? 0 : $urandom_range(0, 19);
            end
            else if (hold_left > 0)
                hold_left--;
            out_stall <= (hold_left != 0);
        end
    end

    task automatic send(input logic [1:0] code, input logic [7:0] data, input logic [6:0] idx);
        int gap;
        if (items_sent % 40 == 0)
            no_gap = ($urandom_range(0, 3) == 0);
        gap = no_gap ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= '{op: code, rx_byte: data, read_index: idx};
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic rx(input logic [7:0] data);
        send(OP_RX, data, 7'($urandom));
    endtask

    task automatic send_frame(input frame_kind_t kind, input int len);
        logic [7:0]  dest;
        logic [7:0]  src;
        logic [7:0]  flen;
        logic [7:0]  chk;
        logic [7:0]  b;
        logic [15:0] fcs;
        int          body;
        dest = node_addr;
        do src = 8'($urandom); while (src == node_addr);
        flen = 8'(len);
        case (kind)
            FR_WRONG_DEST: dest = node_addr ^ 8'($urandom_range(1, 255));
            FR_OWN_SRC:    src = node_addr;
            FR_TOO_LONG:   flen = 8'($urandom_range(DATA_MAX + 1, 255));
            default: ;
        endcase
        chk = HDR_XOR_OK ^ dest ^ src ^ flen;
        if (kind == FR_BAD_XOR)
            chk ^= 8'($urandom_range(1, 255));
        rx(dest);
        rx(src);
        rx(flen);
        rx(chk);
        if (kind == FR_BAD_XOR || kind == FR_WRONG_DEST || kind == FR_OWN_SRC ||
            kind == FR_TOO_LONG)
            return;
        body = (kind == FR_CUT) ? $urandom_range(0, len - 1) : len;
        fcs = CRC_INIT;
        for (int i = 0; i < body; i++)
        begin
            if (len < 2 || i < len - 2)
            begin
                b = 8'($urandom);
                fcs = crc16_byte(fcs, b);
            end
            else
            begin
                if (i == len - 2 && kind == FR_BAD_CRC)
                    fcs ^= 16'(1 << $urandom_range(0, 15));
                b = (i == len - 2) ? fcs[7:0] : fcs[15:8];
            end
            rx(b);
        end
    endtask

    task automatic reader_request();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            send(OP_READ, 8'($urandom),
                 (r == 0) ? 7'($urandom_range(68, 127)) : 7'($urandom_range(0, 67)));
        else if (r < 8)
            send(OP_RELEASE, 8'($urandom), 7'($urandom));
        else
            send(OP_POLL, 8'($urandom), 7'($urandom));
    endtask

    task automatic set_node_addr(input logic [7:0] a);
        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= a;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        node_addr = a;
    endtask

    task automatic random_phase(input int count);
        int stop;
        int r;
        int len;
        stop = items_sent + count;
        while (items_sent < stop)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(2, DATA_MAX)
                                                  : $urandom_range(2, 10);
                r = $urandom_range(0, 99);
                if (r < 60)
                    send_frame(FR_GOOD, len);
                else if (r < 70)
                    send_frame(FR_BAD_CRC, len);
                else if (r < 76)
                    send_frame(FR_CUT, len);
                else if (r < 80)
                    send_frame(FR_GOOD, $urandom_range(0, 1));
                else if (r < 85)
                    send_frame(FR_BAD_XOR, len);
                else if (r < 90)
                    send_frame(FR_WRONG_DEST, len);
                else if (r < 95)
                    send_frame(FR_OWN_SRC, len);
                else
                    send_frame(FR_TOO_LONG, len);
                if ($urandom_range(0, 1) == 0)
                    send(OP_RELEASE, 8'($urandom), 7'($urandom));
                repeat ($urandom_range(0, 2)) reader_request();
            end
            else if (r < 90)
                repeat ($urandom_range(1, 3)) reader_request();
            else
                repeat ($urandom_range(1, 5)) rx(8'($urandom));
        end
    endtask

    initial
    begin
        #5_000_000;
        $display("radio_packet_rx_deframer regression: fail");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_node_addr(8'($urandom_range(1, 254)));

        // full-length frames into both buffers so that every stored byte is defined
        send_frame(FR_GOOD, DATA_MAX);
        send_frame(FR_GOOD, DATA_MAX);

        send(OP_READ, 8'h00, 7'd0);
        send(OP_READ, 8'hFF, 7'd67);
        send(OP_READ, 8'h00, 7'd68);
        send(OP_READ, 8'hFF, 7'd127);
        rx(8'($urandom));
        send(OP_POLL, 8'h00, 7'd0);
        send(OP_RELEASE, 8'h00, 7'd0);
        send(OP_RELEASE, 8'h00, 7'd0);
        send(OP_RELEASE, 8'h00, 7'd0);
        send(OP_POLL, 8'h00, 7'd0);
        send_frame(FR_GOOD, 2);
        send(OP_READ, 8'h00, 7'd2);
        send(OP_RELEASE, 8'h00, 7'd0);
        send_frame(FR_GOOD, 0);
        send(OP_POLL, 8'h00, 7'd0);
        send_frame(FR_GOOD, 1);
        send(OP_POLL, 8'h00, 7'd0);
        send_frame(FR_BAD_XOR, 8);
        send_frame(FR_WRONG_DEST, 8);
        send_frame(FR_OWN_SRC, 8);
        send_frame(FR_TOO_LONG, 8);
        send_frame(FR_BAD_CRC, 5);
        send(OP_POLL, 8'h00, 7'd0);

        phase_addr = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom)};
        foreach (phase_addr[p])
        begin
            set_node_addr(phase_addr[p]);
            random_phase(150);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("radio_packet_rx_deframer regression: pass");
        else
            $display("radio_packet_rx_deframer regression: fail");
        $finish;
    end

endmodule
